// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ktur_pkg.sv =====
// ----------------------------------------------------------------------------
// ktur_pkg
// shared types, codes and defaults of the keyed upsert/remove table
// ----------------------------------------------------------------------------
package ktur_pkg;

    // field widths of the beats
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 16;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    // parameter defaults
    localparam int ENTRIES_DEF       = 64;
    localparam int PAYLOAD_WIDTH_DEF = 64;

    // command codes, any other code behaves as a lookup
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;

    // request beat
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] entry_data;
    } req_beat_t;

    // response beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
    } rsp_beat_t;

endpackage

// ===== src/keyed_table_upsert_remove.sv =====
// ----------------------------------------------------------------------------
// keyed_table_upsert_remove
// dense keyed table with lookup, upsert and remove-with-compaction
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_stall/req): one command beat, taken when
//   req_valid is high and req_stall is low. rsp channel
//   (rsp_valid/rsp_stall/rsp): one status beat per command, in order.
//   records sit in one single-port ram, one key+payload record per slot.
//   the search reads one slot per cycle up to the first match or the
//   live count. a remove then moves every record above the removed one
//   down one slot, a read and a write per record. search, update and
//   shift share the single ram port.
//   one command is worked at a time; req_stall is high from the cycle
//   after acceptance until the result is in the response register.
//   the next command is taken while an earlier result still waits.
//   reset clears the live count, the table reads as empty right away.
//   a stalled response holds and, once a second result is ready, the
//   engine waits for the first to leave before taking more commands.
// ----------------------------------------------------------------------------
module keyed_table_upsert_remove #(
    parameter int ENTRIES       = ktur_pkg::ENTRIES_DEF,
    parameter int PAYLOAD_WIDTH = ktur_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ktur_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ktur_pkg::rsp_beat_t rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int RW = ktur_pkg::KEY_W + PAYLOAD_WIDTH;

    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    // record store
    ktur_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // search / update / shift sequencer
    ktur_engine #(
        .ENTRIES       (ENTRIES),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule

// ===== src/ktur_ram.sv =====
// ----------------------------------------------------------------------------
// ktur_ram
// single-port synchronous ram, one access per cycle, registered read
// ----------------------------------------------------------------------------
module ktur_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read, read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= ram_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ktur_engine.sv =====
// ----------------------------------------------------------------------------
// ktur_engine
// sequencer: linear key search, upsert/remove decision, compaction shift,
// live count and response register
// ----------------------------------------------------------------------------
module ktur_engine #(
    parameter int ENTRIES       = ktur_pkg::ENTRIES_DEF,
    parameter int PAYLOAD_WIDTH = ktur_pkg::PAYLOAD_WIDTH_DEF,
    localparam int IW = $clog2(ENTRIES),
    localparam int RW = ktur_pkg::KEY_W + PAYLOAD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ktur_pkg::req_beat_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ktur_pkg::rsp_beat_t   rsp,
    output logic                  ram_we,
    output logic [IW-1:0]         ram_addr,
    output logic [RW-1:0]         ram_wdata,
    input  logic [RW-1:0]         ram_rdata
);

    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int IXE = IW + ktur_pkg::INDEX_W;
    localparam int CXE = CW + ktur_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [ktur_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [ktur_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0]        data_reg, data_next;
    logic [IW-1:0]                   ptr_reg, ptr_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic                            hit_reg, hit_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [ktur_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    ktur_pkg::rsp_beat_t             rsp_reg, rsp_next;

    logic [ktur_pkg::KEY_W-1:0]      rd_key;
    logic [CW-1:0]                   ptr_ext;
    logic [IXE-1:0]                  idx_wide;
    logic [CXE-1:0]                  count_wide;

    assign rd_key     = ram_rdata[RW-1:PAYLOAD_WIDTH];
    assign ptr_ext    = CW'(ptr_reg);
    assign idx_wide   = IXE'(idx_reg);
    assign count_wide = CXE'(count_reg);

    // next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_addr       = ptr_reg;
        ram_wdata      = {key_reg, data_reg};

        // response taken downstream
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = req.command;
                    key_next  = req.key;
                    data_next = req.entry_data[PAYLOAD_WIDTH-1:0];
                    ptr_next  = '0;
                    ram_addr  = '0;
                    if (count_reg == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            // one slot compared per cycle, next read issued alongside
            S_SEARCH:
            begin
                if (rd_key == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESOLVE;
                end
                else if (ptr_ext + CW'(1) == count_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_RESOLVE;
                end
                else
                begin
                    ptr_next = ptr_reg + IW'(1);
                    ram_addr = ptr_reg + IW'(1);
                end
            end

            // act on the search result
            S_RESOLVE:
            begin
                state_next = S_DONE;
                idx_next   = '0;
                case (cmd_reg)
                    ktur_pkg::CMD_UPSERT:
                    begin
                        if (hit_reg)
                        begin
                            ram_we      = 1'b1;
                            ram_addr    = ptr_reg;
                            idx_next    = ptr_reg;
                            status_next = ktur_pkg::ST_FOUND;
                        end
                        else if (count_reg == CW'(ENTRIES))
                        begin
                            status_next = ktur_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_addr    = IW'(count_reg);
                            idx_next    = IW'(count_reg);
                            count_next  = count_reg + CW'(1);
                            status_next = ktur_pkg::ST_INSERTED;
                        end
                    end
                    ktur_pkg::CMD_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ktur_pkg::ST_MISSING;
                        end
                        else
                        begin
                            idx_next    = ptr_reg;
                            status_next = ktur_pkg::ST_REMOVED;
                            if (ptr_ext + CW'(1) < count_reg)
                            begin
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            idx_next    = ptr_reg;
                            status_next = ktur_pkg::ST_FOUND;
                        end
                        else
                        begin
                            status_next = ktur_pkg::ST_MISSING;
                        end
                    end
                endcase
            end

            // compaction: read the slot above
            S_SH_RD:
            begin
                ram_addr   = ptr_reg + IW'(1);
                state_next = S_SH_WR;
            end

            // compaction: write it one slot down
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_reg + IW'(1);
                if (ptr_ext + CW'(2) < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // hand result to the response register
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.index  = idx_wide[ktur_pkg::INDEX_W-1:0];
                    rsp_next.count  = count_wide[ktur_pkg::COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cmd_reg       <= ktur_pkg::CMD_LOOKUP;
            key_reg       <= '0;
            data_reg      <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            status_reg    <= ktur_pkg::ST_FOUND;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            data_reg      <= data_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            status_reg    <= status_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/ktur_chk.sv =====
// ----------------------------------------------------------------------------
// ktur_chk
// port-level checks of the keyed table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ktur_chk #(
    parameter int ENTRIES = ktur_pkg::ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  ktur_pkg::rsp_beat_t rsp
);

    localparam int CXE = 32 + ktur_pkg::COUNT_W;
    localparam logic [CXE-1:0] FULL_WIDE = CXE'(ENTRIES);
    localparam logic [ktur_pkg::COUNT_W-1:0] FULL_COUNT = FULL_WIDE[ktur_pkg::COUNT_W-1:0];

    logic req_beat;

    assign req_beat = req_valid && !req_stall;

    // stalled response beat holds
    `AST_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp), "response changed while stalled")

    // status is a defined code
    `AST_IMPLY(a_status_code, clk, rst_n, rsp_valid,
        rsp.status == ktur_pkg::ST_FOUND || rsp.status == ktur_pkg::ST_INSERTED ||
        rsp.status == ktur_pkg::ST_FULL || rsp.status == ktur_pkg::ST_MISSING ||
        rsp.status == ktur_pkg::ST_REMOVED, "undefined status code")

    // no slot for refused or missed commands
    `AST_IMPLY(a_idx_zero, clk, rst_n,
        rsp_valid && (rsp.status == ktur_pkg::ST_FULL || rsp.status == ktur_pkg::ST_MISSING),
        rsp.index == '0, "nonzero index on full or not found")

    // a full refusal reports a full table
    `AST_IMPLY(a_full_count, clk, rst_n, rsp_valid && rsp.status == ktur_pkg::ST_FULL,
        rsp.count == FULL_COUNT, "full status with table not full")

    // one command at a time
    `AST_NEXT(a_busy, clk, rst_n, req_beat, req_stall, "request taken while busy")

endmodule

bind keyed_table_upsert_remove ktur_chk #(
    .ENTRIES (ENTRIES)
) u_ktur_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the keyed upsert/remove table against a behavioral copy of the
// table kept in the bench: a directed walk over empty, edge and compaction
// cases, then random command mixes that fill the table to full and remove from it
// ----------------------------------------------------------------------------
module testbench;

    import ktur_pkg::*;

    localparam int TABLE_DEPTH    = ENTRIES_DEF;
    localparam int NUM_DIRECTED   = 22;
    localparam int PHASE_ITEMS    = 380;
    localparam int FILL_AT        = 120;
    localparam int POOL_SIZE      = 32;
    localparam int DRAIN_CYCLES   = 3 * TABLE_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // command code 3 is not named by the block, it acts as a lookup
    localparam logic [CMD_W-1:0] CMD_ALIAS = 2'd3;

    // one row of the directed walk, with an optional typed-in result
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   data;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    // bench copy of the table
    logic [KEY_W-1:0]  tbl_keys     [TABLE_DEPTH];
    logic [DATA_W-1:0] tbl_payloads [TABLE_DEPTH];
    int                tbl_count;
    int                peak_count;

    rsp_beat_t         rsp_due_q [$];
    dir_row_t          directed_rows [NUM_DIRECTED];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatches;
    int beats_sent;
    int status_hits [5];

    keyed_table_upsert_remove #(
        .ENTRIES       (ENTRIES_DEF),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // first live slot holding the key, -1 when absent
    function automatic int find_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    // apply one command to the bench table and return its status beat
    function automatic rsp_beat_t apply_table_op(input req_beat_t b);
        rsp_beat_t r;
        int        hit;
        hit = find_key(b.key);
        r = '0;
        case (b.command)
            CMD_UPSERT:
            begin
                if (hit >= 0)
                begin
                    tbl_payloads[hit] = b.entry_data;
                    r.status = ST_FOUND;
                    r.index  = INDEX_W'(hit);
                end
                else if (tbl_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    tbl_keys[tbl_count]     = b.key;
                    tbl_payloads[tbl_count] = b.entry_data;
                    r.status = ST_INSERTED;
                    r.index  = INDEX_W'(tbl_count);
                    tbl_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_MISSING;
                else
                begin
                    // close the gap so the live slots stay dense
                    for (int i = hit; i + 1 < tbl_count; i++)
                    begin
                        tbl_keys[i]     = tbl_keys[i + 1];
                        tbl_payloads[i] = tbl_payloads[i + 1];
                    end
                    tbl_count--;
                    tbl_keys[tbl_count]     = '0;
                    tbl_payloads[tbl_count] = '0;
                    r.status = ST_REMOVED;
                    r.index  = INDEX_W'(hit);
                end
            end
            default:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_FOUND;
                    r.index  = INDEX_W'(hit);
                end
                else
                    r.status = ST_MISSING;
            end
        endcase
        r.count = COUNT_W'(tbl_count);
        if (tbl_count > peak_count)
            peak_count = tbl_count;
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // drive one request beat, hold it until taken, then queue its result
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] data, input bit typed,
                             input rsp_beat_t want);
        req_beat_t b;
        rsp_beat_t predicted;
        b.command    = cmd;
        b.key        = k;
        b.entry_data = data;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        do
            @(posedge clk);
        while (req_stall);
        predicted = apply_table_op(b);
        rsp_due_q.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // response side: random stall, compare every beat taken
    initial
    begin
        rsp_beat_t want;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due_q.size() == 0)
                    report_mismatch("unexpected response, status", rsp.status, -1);
                else
                begin
                    want = rsp_due_q.pop_front();
                    if (rsp.status != want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.index != want.index)
                        report_mismatch("index", rsp.index, want.index);
                    if (rsp.count != want.count)
                        report_mismatch("count", rsp.count, want.count);
                    if (want.status <= ST_REMOVED)
                        status_hits[want.status]++;
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin
        rsp_beat_t        want;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] k;
        int               pick;
        int               rm_pct;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        mismatches = 0;
        beats_sent = 0;
        tbl_count  = 0;
        peak_count = 0;
        for (int i = 0; i < 5; i++)
            status_hits[i] = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_keys[i]     = '0;
            tbl_payloads[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);

        // empty table, edge keys and payloads, alias command, compaction
        directed_rows = '{
            '{CMD_LOOKUP, 16'h0000, 64'h0,                   1'b1, ST_MISSING,  6'd0, 7'd0},
            '{CMD_REMOVE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_MISSING,  6'd0, 7'd0},
            '{CMD_ALIAS,  16'h0000, 64'h0,                   1'b1, ST_MISSING,  6'd0, 7'd0},
            '{CMD_UPSERT, 16'h0000, 64'h0,                   1'b1, ST_INSERTED, 6'd0, 7'd1},
            '{CMD_UPSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED, 6'd1, 7'd2},
            '{CMD_UPSERT, 16'h8000, 64'h8000_0000_0000_0000, 1'b1, ST_INSERTED, 6'd2, 7'd3},
            '{CMD_UPSERT, 16'h0001, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED, 6'd3, 7'd4},
            '{CMD_LOOKUP, 16'hFFFF, 64'h0,                   1'b1, ST_FOUND,    6'd1, 7'd4},
            '{CMD_ALIAS,  16'h8000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_FOUND,    6'd2, 7'd4},
            '{CMD_UPSERT, 16'hFFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_FOUND,    6'd1, 7'd4},
            '{CMD_LOOKUP, 16'h1234, 64'h0,                   1'b1, ST_MISSING,  6'd0, 7'd4},
            '{CMD_REMOVE, 16'h0000, 64'h0,                   1'b1, ST_REMOVED,  6'd0, 7'd3},
            '{CMD_LOOKUP, 16'h0001, 64'h0,                   1'b1, ST_FOUND,    6'd2, 7'd3},
            '{CMD_REMOVE, 16'h0001, 64'h0,                   1'b1, ST_REMOVED,  6'd2, 7'd2},
            '{CMD_REMOVE, 16'h0001, 64'h0,                   1'b1, ST_MISSING,  6'd0, 7'd2},
            '{CMD_UPSERT, 16'h7FFF, 64'h1,                   1'b1, ST_INSERTED, 6'd2, 7'd3},
            '{CMD_REMOVE, 16'h8000, 64'h0,                   1'b1, ST_REMOVED,  6'd1, 7'd2},
            '{CMD_LOOKUP, 16'h7FFF, 64'h0,                   1'b1, ST_FOUND,    6'd1, 7'd2},
            '{CMD_UPSERT, 16'h8000, 64'hFFFF_0000_FFFF_0000, 1'b0, ST_FOUND,    6'd0, 7'd0},
            '{CMD_ALIAS,  16'h7FFF, 64'h0,                   1'b0, ST_FOUND,    6'd0, 7'd0},
            '{CMD_UPSERT, 16'h0000, 64'h0000_FFFF_0000_FFFF, 1'b0, ST_FOUND,    6'd0, 7'd0},
            '{CMD_REMOVE, 16'hFFFF, 64'h0,                   1'b0, ST_FOUND,    6'd0, 7'd0}
        };

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        foreach (directed_rows[i])
        begin
            want.status = directed_rows[i].status;
            want.index  = directed_rows[i].index;
            want.count  = directed_rows[i].count;
            send_beat(directed_rows[i].command, directed_rows[i].key, directed_rows[i].data,
                      directed_rows[i].typed, want);
        end

        // random mixes: receiver-heavy idle, sender-heavy idle, no idle
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 36;
                    receiver_idle_pct = 47;
                end
                1:
                begin
                    sender_idle_pct   = 47;
                    receiver_idle_pct = 36;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // fill burst: insert until full, then refused inserts
                if (n == FILL_AT)
                begin
                    while (tbl_count < TABLE_DEPTH)
                        send_beat(CMD_UPSERT, KEY_W'($urandom), {$urandom, $urandom},
                                  1'b0, '0);
                    repeat (3)
                    begin
                        do
                            k = KEY_W'($urandom);
                        while (find_key(k) >= 0);
                        send_beat(CMD_UPSERT, k, {$urandom, $urandom}, 1'b0, '0);
                    end
                end

                // removes grow more likely as the table fills
                rm_pct = 10 + (tbl_count * 40) / TABLE_DEPTH;
                pick   = $urandom_range(0, 99);
                if (pick < rm_pct)
                    cmd = CMD_REMOVE;
                else if (pick < rm_pct + 40)
                    cmd = CMD_UPSERT;
                else if (pick < rm_pct + 45)
                    cmd = CMD_ALIAS;
                else
                    cmd = CMD_LOOKUP;

                // mostly live or recurring keys, some fully random
                pick = $urandom_range(0, 99);
                if (pick < 55 && tbl_count > 0)
                    k = tbl_keys[$urandom_range(0, tbl_count - 1)];
                else if (pick < 85)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    k = KEY_W'($urandom);

                send_beat(cmd, k, {$urandom, $urandom}, 1'b0, '0);
            end

            // hold off until every pending result has come back
            req_valid <= 1'b0;
            while (rsp_due_q.size() != 0)
                @(posedge clk);
        end

        // drain, then watch for stray responses
        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands over three idle mixes, peak live count %0d of %0d",
                 beats_sent, peak_count, TABLE_DEPTH);
        $display("results: found %0d, inserted %0d, full %0d, missing %0d, removed %0d",
                 status_hits[ST_FOUND], status_hits[ST_INSERTED], status_hits[ST_FULL],
                 status_hits[ST_MISSING], status_hits[ST_REMOVED]);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ktur_pkg.sv
src/ktur_ram.sv
src/ktur_engine.sv
src/keyed_table_upsert_remove.sv
src/ktur_chk.sv
bench/testbench.sv
